/* rtl/core/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is low
`define NLC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("nlc assertion failed");

// clocked assertion that also holds during reset
`define NLC_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("nlc assertion failed during reset");

`endif

/* rtl/core/nlc_pkg.sv */
package nlc_pkg;

  localparam int unsigned Entries   = 64;
  localparam int unsigned IdxW      = $clog2(Entries);
  localparam int unsigned CntW      = $clog2(Entries + 1);
  localparam int unsigned SlotW     = 6;
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [31:0] HashSeed = 32'd5381;

  localparam logic KindLookup = 1'b0;
  localparam logic KindAdd    = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] parent_id;
    logic [15:0] child_id;
    logic [7:0]  name_byte;
    logic        name_last;
  } in_word_t;

  typedef struct packed {
    logic             found;
    logic [15:0]      result_child;
    logic [SlotW-1:0] slot_index;
  } out_word_t;

  // finished name, handed from front to back
  typedef struct packed {
    logic        kind;
    logic [15:0] parent;
    logic [15:0] child;
    logic [31:0] hash;
  } cmd_t;

  typedef struct packed {
    logic [15:0] parent;
    logic [31:0] hash;
    logic [15:0] child;
    logic [31:0] age;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // djb2 fold: h * 33 + byte, modulo 2^32
  function automatic logic [31:0] djb2_step(logic [31:0] h, logic [7:0] b);
    return (h << 5) + h + {24'd0, b};
  endfunction

endpackage

/* rtl/core/nlc_cmd_fifo.sv */
module nlc_cmd_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  nlc_pkg::cmd_t        data_i,
  input  logic                 pop_i,
  output nlc_pkg::cmd_t        data_o,
  output nlc_pkg::q_status_t   stat_o
);

  nlc_pkg::cmd_t                     store_q [nlc_pkg::FifoDepth];
  logic [nlc_pkg::FifoPtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [nlc_pkg::FifoPtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [nlc_pkg::FifoCntW-1:0]      count_q, count_d;
  logic                              do_push, do_pop;

  localparam logic [nlc_pkg::FifoPtrW-1:0] LastPtr =
    nlc_pkg::FifoPtrW'(nlc_pkg::FifoDepth - 1);

  assign stat_o.full  = (count_q == nlc_pkg::FifoCntW'(nlc_pkg::FifoDepth));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* rtl/core/nlc_front.sv */
module nlc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  nlc_pkg::in_word_t   in_word_i,
  input  nlc_pkg::q_status_t  q_stat_i,
  output logic                push_o,
  output nlc_pkg::cmd_t       cmd_o
);

  logic [31:0] hash_q, hash_d, hash_next;
  logic        accept;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;
  assign hash_next  = nlc_pkg::djb2_step(hash_q, in_word_i.name_byte);

  // last byte restarts the fold for the next name
  always_comb begin
    hash_d = hash_q;
    if (accept) begin
      hash_d = in_word_i.name_last ? nlc_pkg::HashSeed : hash_next;
    end
  end

  assign push_o = accept && in_word_i.name_last;
  assign cmd_o  = '{kind:   in_word_i.kind,
                    parent: in_word_i.parent_id,
                    child:  in_word_i.child_id,
                    hash:   hash_next};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= nlc_pkg::HashSeed;
    end else begin
      hash_q <= hash_d;
    end
  end

endmodule

/* rtl/core/nlc_back.sv */
module nlc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nlc_pkg::q_status_t  q_stat_i,
  input  nlc_pkg::cmd_t       cmd_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output nlc_pkg::out_word_t  out_word_o
);

  localparam logic [1:0] SIdle  = 2'd0;
  localparam logic [1:0] SScan  = 2'd1;
  localparam logic [1:0] SWrite = 2'd2;

  localparam logic [nlc_pkg::CntW-1:0] CntFull  = nlc_pkg::CntW'(nlc_pkg::Entries);
  localparam logic [nlc_pkg::IdxW-1:0] IdxLast  = nlc_pkg::IdxW'(nlc_pkg::Entries - 1);

  nlc_pkg::entry_t                  mem [nlc_pkg::Entries];

  logic [1:0]                       state_q, state_d;
  nlc_pkg::cmd_t                    cmd_q, cmd_d;
  logic [nlc_pkg::CntW-1:0]         addr_q, addr_d;
  logic                             cmp_vld_q, cmp_vld_d;
  logic [nlc_pkg::IdxW-1:0]         cmp_idx_q, cmp_idx_d;
  logic [nlc_pkg::IdxW-1:0]         best_idx_q, best_idx_d;
  logic [31:0]                      best_age_q, best_age_d;
  logic [nlc_pkg::IdxW-1:0]         slot_q, slot_d;
  logic [nlc_pkg::CntW-1:0]         fill_q, fill_d;
  logic [31:0]                      age_clk_q, age_clk_d;
  logic [nlc_pkg::Entries-1:0]      valid_q, valid_d;
  logic                             out_valid_q, out_valid_d;
  nlc_pkg::out_word_t               out_word_q, out_word_d;

  nlc_pkg::entry_t                  rd_data_q;
  logic                             rd_valid_q;
  logic                             rd_en, wr_en;
  logic [nlc_pkg::IdxW-1:0]         wr_addr;
  nlc_pkg::entry_t                  wr_data;

  logic out_free, issue, match, last_cmp, older, not_full;

  assign out_free = !out_valid_q || !out_stall_i;
  assign issue    = (state_q == SScan) && (addr_q < CntFull);
  assign match    = cmp_vld_q && rd_valid_q && (rd_data_q.parent == cmd_q.parent)
                    && (rd_data_q.hash == cmd_q.hash);
  assign last_cmp = cmp_vld_q && (cmp_idx_q == IdxLast);
  assign older    = (cmp_idx_q == '0) || (rd_data_q.age < best_age_q);
  assign not_full = (fill_q < CntFull);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    addr_d      = addr_q;
    cmp_vld_d   = cmp_vld_q;
    cmp_idx_d   = cmp_idx_q;
    best_idx_d  = best_idx_q;
    best_age_d  = best_age_q;
    slot_d      = slot_q;
    fill_d      = fill_q;
    age_clk_d   = age_clk_q;
    valid_d     = valid_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_word_d  = out_word_q;
    pop_o       = 1'b0;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = slot_q;
    wr_data     = rd_data_q;

    unique case (state_q)
      SIdle: begin
        if (!q_stat_i.empty) begin
          pop_o = 1'b1;
          cmd_d = cmd_i;
          if (cmd_i.kind == nlc_pkg::KindAdd && not_full) begin
            slot_d  = fill_q[nlc_pkg::IdxW-1:0];
            state_d = SWrite;
          end else begin
            addr_d    = '0;
            cmp_vld_d = 1'b0;
            state_d   = SScan;
          end
        end
      end
      SScan: begin
        if (cmd_q.kind == nlc_pkg::KindLookup && (match || last_cmp)) begin
          // finish the lookup; hold everything while the output is blocked
          if (out_free) begin
            out_valid_d = 1'b1;
            out_word_d  = '{found:        match,
                            result_child: match ? rd_data_q.child : 16'd0,
                            slot_index:   match ? nlc_pkg::SlotW'(cmp_idx_q) : '0};
            if (match) begin
              wr_en        = 1'b1;
              wr_addr      = cmp_idx_q;
              wr_data.age  = age_clk_q + 32'd1;
              age_clk_d    = age_clk_q + 32'd1;
            end
            state_d = SIdle;
          end
        end else begin
          rd_en     = issue;
          cmp_vld_d = issue;
          cmp_idx_d = addr_q[nlc_pkg::IdxW-1:0];
          if (issue) begin
            addr_d = addr_q + 1'b1;
          end
          // victim search: oldest age, lowest index on ties
          if (cmd_q.kind == nlc_pkg::KindAdd && cmp_vld_q) begin
            if (older) begin
              best_idx_d = cmp_idx_q;
              best_age_d = rd_data_q.age;
            end
            if (last_cmp) begin
              slot_d  = older ? cmp_idx_q : best_idx_q;
              state_d = SWrite;
            end
          end
        end
      end
      SWrite: begin
        if (out_free) begin
          wr_en            = 1'b1;
          wr_addr          = slot_q;
          wr_data          = '{parent: cmd_q.parent, hash: cmd_q.hash,
                               child:  cmd_q.child,  age:  age_clk_q + 32'd1};
          age_clk_d        = age_clk_q + 32'd1;
          valid_d[slot_q]  = 1'b1;
          if (not_full) begin
            fill_d = fill_q + 1'b1;
          end
          out_valid_d = 1'b1;
          out_word_d  = '{found:        1'b1,
                          result_child: cmd_q.child,
                          slot_index:   nlc_pkg::SlotW'(slot_q)};
          state_d     = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      addr_q      <= '0;
      cmp_vld_q   <= 1'b0;
      fill_q      <= '0;
      age_clk_q   <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      cmp_vld_q   <= cmp_vld_d;
      fill_q      <= fill_d;
      age_clk_q   <= age_clk_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    cmp_idx_q  <= cmp_idx_d;
    best_idx_q <= best_idx_d;
    best_age_q <= best_age_d;
    slot_q     <= slot_d;
    out_word_q <= out_word_d;
  end

  // entry table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q  <= mem[addr_q[nlc_pkg::IdxW-1:0]];
      rd_valid_q <= valid_q[addr_q[nlc_pkg::IdxW-1:0]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

/* rtl/core/name_lookup_cache_lru.sv */
// name lookup cache, fully associative, least-recently-used replacement
// input channel: one name byte per word (in_valid_i / in_stall_o / in_word_i);
//   bytes are folded into a djb2 hash, and the word flagged name_last runs the
//   operation picked by kind (lookup or add) on parent id and finished hash
// output channel: one word per last byte (out_valid_o / out_stall_i / out_word_o),
//   carrying found, result_child and slot_index; a miss gives zeros
// input bytes: the front keeps taking bytes while the back works, until the
//   two-deep command queue fills and in_stall_o holds every byte
// path of a last byte through the back (an idle back, a free output): an add into
//   a free slot goes from SIdle straight to SWrite; a lookup scans the entries
//   through the single read port from entry 0 until a hit (a miss scans all);
//   an add into a full table scans all entries for the oldest age, then writes
// reset: table valid bits, fill count and age clock clear at once; the hash
//   restarts from 5381; no clearing pass is needed
// a stalled output word holds its value; the back waits with its result until
//   the output register frees, and the queue then backs up to in_stall_o
module name_lookup_cache_lru (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  nlc_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output nlc_pkg::out_word_t out_word_o
);

  // queue between hashing front and table back
  nlc_pkg::q_status_t q_stat;
  nlc_pkg::cmd_t      cmd_push;
  nlc_pkg::cmd_t      cmd_head;
  logic               push;
  logic               pop;

  // front: folds bytes, queues one command per name
  nlc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .cmd_o      (cmd_push)
  );

  nlc_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (cmd_push),
    .pop_i  (pop),
    .data_o (cmd_head),
    .stat_o (q_stat)
  );

  // back: scans the table, writes entries, drives the output register
  nlc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .cmd_i       (cmd_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

/* rtl/core/nlc_checker.sv */
`include "assert_macros.svh"

module nlc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_i,
  input nlc_pkg::in_word_t  in_word_i,
  input logic               out_valid_i,
  input logic               out_stall_i,
  input nlc_pkg::out_word_t out_word_i
);

  logic [3:0] pend_q, pend_d;
  logic       name_in, word_out;
  logic       out_held, miss_word, miss_clean;

  assign name_in    = in_valid_i && !in_stall_i && in_word_i.name_last;
  assign word_out   = out_valid_i && !out_stall_i;
  assign out_held   = out_valid_i && out_stall_i;
  assign miss_word  = out_valid_i && !out_word_i.found;
  assign miss_clean = (out_word_i.result_child == 16'd0) && (out_word_i.slot_index == '0);

  // names taken but not yet answered
  always_comb begin
    pend_d = pend_q;
    if (name_in && !word_out) begin
      pend_d = pend_q + 4'd1;
    end else if (word_out && !name_in) begin
      pend_d = pend_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `NLC_ASSERT(a_out_hold, clk_i, rst_ni, out_held |=> out_valid_i && $stable(out_word_i))
  `NLC_ASSERT(a_no_orphan, clk_i, rst_ni, out_valid_i |-> pend_q != 4'd0)
  `NLC_ASSERT(a_miss_zero, clk_i, rst_ni, miss_word |-> miss_clean)
  `NLC_ASSERT_NORST(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_i)

endmodule

bind name_lookup_cache_lru nlc_checker u_nlc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_i  (out_word_o)
);

/* tb/tb_name_lookup_cache_lru.sv */
`timescale 1ns / 100ps

module tb_name_lookup_cache_lru;

  // run length and pressure points
  localparam int unsigned NameBytes  = 1250;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned HoldAt     = 120;    // reply count at which the sink holds off
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned PauseAtOp  = 250;    // op at which the source drains

  // a name as the source sends it: parent plus up to six bytes, first byte lowest
  typedef struct packed {
    logic [15:0] parent;
    logic [2:0]  len;
    logic [47:0] text;
  } name_t;

  // mirror of the cache table plus the queue of replies still owed
  class cache_tracker;
    logic [31:0]        hash_acc;
    logic               slot_used   [nlc_pkg::Entries];
    logic [15:0]        slot_parent [nlc_pkg::Entries];
    logic [31:0]        slot_hash   [nlc_pkg::Entries];
    logic [15:0]        slot_child  [nlc_pkg::Entries];
    logic [31:0]        slot_age    [nlc_pkg::Entries];
    logic [31:0]        age_clock;
    int unsigned        fill_count;
    nlc_pkg::out_word_t pending_replies[$];
    int unsigned        fail_count;

    function new();
      for (int i = 0; i < nlc_pkg::Entries; i++) begin
        slot_used[i]   = 1'b0;
        slot_parent[i] = '0;
        slot_hash[i]   = '0;
        slot_child[i]  = '0;
        slot_age[i]    = '0;
      end
      hash_acc   = nlc_pkg::HashSeed;
      age_clock  = '0;
      fill_count = 0;
      fail_count = 0;
    endfunction

    // fold one accepted byte; a last byte runs lookup or add and owes a reply
    function void note_byte(nlc_pkg::in_word_t w);
      logic [31:0]        h;
      nlc_pkg::out_word_t r;
      int                 hit;
      int                 slot;
      h = hash_acc * 32'd33 + {24'd0, w.name_byte};
      if (!w.name_last) begin
        hash_acc = h;
        return;
      end
      hash_acc = nlc_pkg::HashSeed;
      if (w.kind == nlc_pkg::KindLookup) begin
        hit = -1;
        for (int i = 0; i < nlc_pkg::Entries; i++)
          if (hit < 0 && slot_used[i] && slot_parent[i] == w.parent_id && slot_hash[i] == h)
            hit = i;
        if (hit < 0) begin
          r = '0;
        end else begin
          age_clock      = age_clock + 32'd1;
          slot_age[hit]  = age_clock;
          r.found        = 1'b1;
          r.result_child = slot_child[hit];
          r.slot_index   = hit[nlc_pkg::SlotW-1:0];
        end
      end else begin
        if (fill_count < nlc_pkg::Entries) begin
          slot       = fill_count;
          fill_count = fill_count + 1;
        end else begin
          // oldest age wins, lowest index on ties
          slot = 0;
          for (int i = 1; i < nlc_pkg::Entries; i++)
            if (slot_age[i] < slot_age[slot]) slot = i;
        end
        age_clock         = age_clock + 32'd1;
        slot_used[slot]   = 1'b1;
        slot_parent[slot] = w.parent_id;
        slot_hash[slot]   = h;
        slot_child[slot]  = w.child_id;
        slot_age[slot]    = age_clock;
        r.found           = 1'b1;
        r.result_child    = w.child_id;
        r.slot_index      = slot[nlc_pkg::SlotW-1:0];
      end
      pending_replies.push_back(r);
    endfunction

    // compare one accepted reply with the oldest one owed
    function void check_reply(nlc_pkg::out_word_t got);
      nlc_pkg::out_word_t want;
      if (pending_replies.size() == 0) begin
        $error("reply word with none owed: %h", got);
        fail_count++;
        return;
      end
      want = pending_replies.pop_front();
      if (got.found !== want.found) begin
        $error("found: expected %0h, got %0h", want.found, got.found);
        fail_count++;
      end
      if (got.result_child !== want.result_child) begin
        $error("result_child: expected %0h, got %0h", want.result_child, got.result_child);
        fail_count++;
      end
      if (got.slot_index !== want.slot_index) begin
        $error("slot_index: expected %0d, got %0d", want.slot_index, got.slot_index);
        fail_count++;
      end
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  nlc_pkg::in_word_t  in_word   = '0;
  logic               out_stall = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  nlc_pkg::out_word_t out_word_o;

  cache_tracker tracker = new();

  int unsigned bytes_sent  = 0;
  int unsigned words_taken = 0;
  int unsigned op_count    = 0;
  bit          send_calm   = 1'b0;
  name_t       pool[$];    // names already added, source of hits

  name_lookup_cache_lru dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_word_o (out_word_o)
  );

  always #5 clk = ~clk;

  // handshakes are sampled at the edge, before the block's own updates land
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall_o) tracker.note_byte(in_word);
    if (rst_n && out_valid_o && !out_stall) tracker.check_reply(out_word_o);
  end

  // send one byte word: random gap (or none in calm stretches), then hold until taken
  task automatic send_byte(input nlc_pkg::in_word_t w);
    int gap;
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    bytes_sent++;
  endtask

  // send a whole name; only the last byte's kind, parent and child count
  task automatic run_name(input name_t nm, input logic op, input logic [15:0] child);
    nlc_pkg::in_word_t w;
    for (int j = 0; j < nm.len; j++) begin
      w.kind      = (j == nm.len - 1) ? op : 1'($urandom);
      w.parent_id = (j == nm.len - 1) ? nm.parent : 16'($urandom);
      w.child_id  = (j == nm.len - 1) ? child : 16'($urandom);
      w.name_byte = nm.text[8*j +: 8];
      w.name_last = (j == nm.len - 1);
      send_byte(w);
    end
  endtask

  // source goes quiet until every owed reply is back
  task automatic wait_for_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_replies.size() != 0) @(posedge clk);
  endtask

  // a few parents recur so names share directories; some are fully random
  function automatic name_t fresh_name();
    name_t nm;
    case ($urandom_range(0, 3))
      0:       nm.parent = 16'h0000;
      1:       nm.parent = 16'hFFFF;
      2:       nm.parent = 16'h0042;
      default: nm.parent = 16'($urandom);
    endcase
    nm.len  = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 6))
                                          : 3'($urandom_range(1, 3));
    nm.text = 48'({$urandom, $urandom});
    return nm;
  endfunction

  function automatic name_t make_name(input logic [15:0] parent, input logic [2:0] len,
                                      input logic [47:0] text);
    name_t nm;
    nm.parent = parent;
    nm.len    = len;
    nm.text   = text;
    return nm;
  endfunction

  // reply sink: random stalls per word, calm stretches, one long hold-off
  initial begin : reply_sink
    int  k;
    bit  calm;
    calm = 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) calm = !calm;
      k = calm ? 0 : $urandom_range(0, 11);
      // long hold so the command queue fills and the input stalls
      if (words_taken == HoldAt) k = HoldCycles;
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid_o) @(posedge clk);
      words_taken++;
    end
  end

  // watchdog
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    name_t nm;
    int    pick;
    int    idx;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // lookup on an empty table misses
    run_name(make_name(16'h0000, 3'd1, 48'h00), nlc_pkg::KindLookup, 16'hFFFF);
    // single-byte names at both extremes fill slots 0 and 1
    nm = make_name(16'hFFFF, 3'd1, 48'hFF);
    pool.push_back(nm);
    run_name(nm, nlc_pkg::KindAdd, 16'hFFFF);
    nm = make_name(16'h0000, 3'd1, 48'h00);
    pool.push_back(nm);
    run_name(nm, nlc_pkg::KindAdd, 16'h0000);
    run_name(make_name(16'hFFFF, 3'd1, 48'hFF), nlc_pkg::KindLookup, 16'h0000);
    run_name(make_name(16'h0000, 3'd1, 48'h00), nlc_pkg::KindLookup, 16'hFFFF);
    // same byte, other parent: miss
    run_name(make_name(16'h0000, 3'd1, 48'hFF), nlc_pkg::KindLookup, 16'h0000);
    // multi-byte name added twice: lookup returns the lower slot
    nm = make_name(16'h1234, 3'd3, 48'h636261);
    pool.push_back(nm);
    run_name(nm, nlc_pkg::KindAdd, 16'hBEEF);
    run_name(nm, nlc_pkg::KindAdd, 16'h5555);
    run_name(nm, nlc_pkg::KindLookup, 16'h0000);
    // prefix of a stored name misses
    run_name(make_name(16'h1234, 3'd2, 48'h6261), nlc_pkg::KindLookup, 16'h0000);
    nm = make_name(16'hA5A5, 3'd5, 48'h80_7F_01_FE_5A);
    pool.push_back(nm);
    run_name(nm, nlc_pkg::KindAdd, 16'h5A5A);

    // random traffic: mostly adds and lookups of known names, some misses
    while (bytes_sent < NameBytes) begin
      op_count++;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        nm = fresh_name();
        pool.push_back(nm);
        run_name(nm, nlc_pkg::KindAdd, 16'($urandom));
      end else if (pick < 45) begin
        // duplicate add of a known name
        idx = $urandom_range(0, pool.size() - 1);
        run_name(pool[idx], nlc_pkg::KindAdd, 16'($urandom));
      end else if (pick < 85) begin
        // favor recent names so most lookups still hit after replacement starts
        if (pool.size() > 48 && $urandom_range(0, 3) != 0)
          idx = pool.size() - 1 - $urandom_range(0, 47);
        else
          idx = $urandom_range(0, pool.size() - 1);
        run_name(pool[idx], nlc_pkg::KindLookup, 16'($urandom));
      end else if (pick < 93) begin
        run_name(fresh_name(), nlc_pkg::KindLookup, 16'($urandom));
      end else begin
        // known bytes under a neighboring parent
        nm = pool[$urandom_range(0, pool.size() - 1)];
        nm.parent = nm.parent ^ 16'h0001;
        run_name(nm, nlc_pkg::KindLookup, 16'($urandom));
      end
      if (op_count == PauseAtOp || $urandom_range(0, 79) == 0) wait_for_replies();
    end

    // drain, then allow a worst-case scan for any stray reply
    wait_for_replies();
    repeat (nlc_pkg::Entries + 8) @(posedge clk);
    if (tracker.fail_count == 0 && tracker.pending_replies.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
